/* hdl/lfp_pkg.sv */
// Shared types, constants and the duty mapping for the line-follow PID omni drive.
// Used by the top level, front end, divider and back end; depends on nothing.
package lfp_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT    = 3'd4;

    localparam logic [15:0] RST_PROP_GAIN     = 16'd1024;
    localparam logic [15:0] RST_INTEG_GAIN    = 16'd128;
    localparam logic [15:0] RST_DERIV_GAIN    = 16'd307;
    localparam logic [6:0]  RST_FORWARD_SPEED = 7'd20;
    localparam logic [6:0]  RST_TURN_LIMIT    = 7'd40;

    // Datapath widths.
    localparam int WIDE_W = 52;
    localparam int QUO_W  = 25;
    localparam int MS_W   = 16;

    // Fixed-point scale factors.
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam int          LIM_NUM     = 25600000;
    localparam int          LIM_NO_KI   = 100000000;
    localparam int          SCALE_MS    = 1000;
    localparam int          SCALE_DERIV = 1000000;
    localparam int          SCALE_DEN   = 256000;
    localparam int          SCALE_FULL  = 25600000;
    localparam int          LOST_VY     = 10;
    localparam int          LOST_TURN   = 12;
    localparam logic [4:0]  ITERS_LIM   = 5'd25;
    localparam logic [4:0]  ITERS_RND   = 5'd8;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [6:0]  vy;
        logic [6:0]  tl;
    } t_cfg;

    typedef struct packed {
        logic [3:0][7:0] duty;
        logic [3:0]      rev;
        logic            lost;
        logic [7:0]      turn;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] den;
        logic [4:0]        iters;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    // Percent magnitude to duty: 0 stays 0, else 150 + floor((p-1)*105/99).
    // The divide by 99 is a multiply by ceil(2^20/99) and a shift.
    function automatic logic [7:0] duty_of(input logic [6:0] p);
        logic [6:0]  pc;
        logic [13:0] y;
        logic [27:0] t;
        pc = (p > PCT_MAX) ? PCT_MAX : p;
        y  = 14'(pc - 7'd1) * 14'd105;
        t  = 28'(y) * 28'd10592;
        if (pc == 7'd0) begin
            duty_of = 8'd0;
        end else begin
            duty_of = 8'd150 + t[27:20];
        end
    endfunction

endpackage

/* hdl/line_follow_pid_omni_drive.sv */
// Channel  | Handshake                    | Payload
// in       | i_in_valid / o_in_ready      | i_sensor_mask, i_elapsed_ms
// out      | o_out_valid / i_out_ready    | o_duty_wheel0..3, o_reverse_wheel0..3, o_line_lost, o_turn_rate
// cfg      | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// A step with the line seen runs the mask scan over SENSOR_COUNT sensors, the serial divider
// for centroid, integral limit (skipped when integ_gain is zero) and five rounded quotients,
// and the products on the single shared multiplier. A lost-line step goes from the queue
// straight to mixing and the five rounded quotients.
// The input queue holds two beats, and a finished result waits in the output register
// while the next step runs. Reset is synchronous, active low, and clears integral and last error.
// Top level: configuration registers and the front, back and divider instances.
// Depends on lfp_pkg, lfp_front, lfp_div and lfp_core.
module line_follow_pid_omni_drive #(
    parameter int SENSOR_COUNT = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [SENSOR_COUNT-1:0]         i_sensor_mask,
    input  logic [15:0]                     i_elapsed_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_duty_wheel0,
    output logic                            o_reverse_wheel0,
    output logic [7:0]                      o_duty_wheel1,
    output logic                            o_reverse_wheel1,
    output logic [7:0]                      o_duty_wheel2,
    output logic                            o_reverse_wheel2,
    output logic [7:0]                      o_duty_wheel3,
    output logic                            o_reverse_wheel3,
    output logic                            o_line_lost,
    output logic signed [7:0]               o_turn_rate,
    input  logic                            i_cfg_we,
    input  logic [lfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lfp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lfp_pkg::*;

    t_cfg                    r_cfg;
    logic                    w_q_valid, w_q_pop, w_q_lost;
    logic [SENSOR_COUNT-1:0] w_q_mask;
    logic [MS_W-1:0]         w_q_ms;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;
    t_result                 w_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp <= RST_PROP_GAIN;
            r_cfg.ki <= RST_INTEG_GAIN;
            r_cfg.kd <= RST_DERIV_GAIN;
            r_cfg.vy <= RST_FORWARD_SPEED;
            r_cfg.tl <= RST_TURN_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:     r_cfg.kp <= i_cfg_data;
                REG_INTEG_GAIN:    r_cfg.ki <= i_cfg_data;
                REG_DERIV_GAIN:    r_cfg.kd <= i_cfg_data;
                REG_FORWARD_SPEED: r_cfg.vy <= i_cfg_data[6:0];
                REG_TURN_LIMIT:    r_cfg.tl <= i_cfg_data[6:0];
                default:           r_cfg    <= r_cfg;
            endcase
        end
    end

    lfp_front #(.SENSOR_COUNT(SENSOR_COUNT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mask     (i_sensor_mask),
        .i_ms       (i_elapsed_ms),
        .o_q_valid  (w_q_valid),
        .i_pop      (w_q_pop),
        .o_mask     (w_q_mask),
        .o_ms       (w_q_ms),
        .o_lost     (w_q_lost)
    );

    lfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lfp_core #(.SENSOR_COUNT(SENSOR_COUNT)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_mask    (w_q_mask),
        .i_q_ms      (w_q_ms),
        .i_q_lost    (w_q_lost),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_duty_wheel0    = w_result.duty[0];
    assign o_duty_wheel1    = w_result.duty[1];
    assign o_duty_wheel2    = w_result.duty[2];
    assign o_duty_wheel3    = w_result.duty[3];
    assign o_reverse_wheel0 = w_result.rev[0];
    assign o_reverse_wheel1 = w_result.rev[1];
    assign o_reverse_wheel2 = w_result.rev[2];
    assign o_reverse_wheel3 = w_result.rev[3];
    assign o_line_lost      = w_result.lost;
    assign o_turn_rate      = $signed(w_result.turn);

endmodule

/* hdl/lfp_front.sv */
// Front end: takes sensor beats, flags an empty mask, and holds them in a two-entry queue.
// Depends on lfp_pkg.
module lfp_front #(
    parameter int SENSOR_COUNT = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SENSOR_COUNT-1:0] i_mask,
    input  logic [lfp_pkg::MS_W-1:0] i_ms,
    output logic                    o_q_valid,
    input  logic                    i_pop,
    output logic [SENSOR_COUNT-1:0] o_mask,
    output logic [lfp_pkg::MS_W-1:0] o_ms,
    output logic                    o_lost
);
    import lfp_pkg::*;

    logic [SENSOR_COUNT-1:0] r_mask [2];
    logic [MS_W-1:0]         r_ms   [2];
    logic                    r_lost [2];
    logic                    r_wp, r_rp;
    logic [1:0]              r_cnt;
    logic                    w_push, w_pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && o_q_valid;
    assign o_mask     = r_mask[r_rp];
    assign o_ms       = r_ms[r_rp];
    assign o_lost     = r_lost[r_rp];

    // Queue storage; the line is lost when no sensor bit is set.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mask[r_wp] <= i_mask;
            r_ms[r_wp]   <= i_ms;
            r_lost[r_wp] <= (i_mask == '0);
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

/* hdl/lfp_div.sv */
// Shared serial restoring divider: one quotient bit per cycle, quotient width set per request.
// Depends on lfp_pkg.
module lfp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfp_pkg::t_div_req i_req,
    output lfp_pkg::t_div_rsp o_rsp
);
    import lfp_pkg::*;

    localparam int DSH_W = WIDE_W + QUO_W;

    logic [WIDE_W-1:0] r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [4:0]        r_cnt;
    logic [QUO_W-1:0]  r_quo;
    logic              r_busy;
    logic              r_done;
    logic              w_ge;

    assign w_ge        = {{QUO_W{1'b0}}, r_rem} >= r_dsh;
    assign o_rsp.done  = r_done;
    assign o_rsp.quo   = r_quo;

    // Compare against the divisor shifted to the current quotient bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num;
                r_dsh  <= {{QUO_W{1'b0}}, i_req.den} << (i_req.iters - 5'd1);
                r_cnt  <= i_req.iters;
                r_quo  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[WIDE_W-1:0];
                end
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/lfp_core.sv */
// Back end: centroid, PID with clamped integral and turn, wheel mixing, rescale and duty
// mapping. Depends on lfp_pkg; drives the shared divider lfp_div.
module lfp_core #(
    parameter int SENSOR_COUNT = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lfp_pkg::t_cfg            i_cfg,
    input  logic                     i_q_valid,
    output logic                     o_q_pop,
    input  logic [SENSOR_COUNT-1:0]  i_q_mask,
    input  logic [lfp_pkg::MS_W-1:0] i_q_ms,
    input  logic                     i_q_lost,
    output lfp_pkg::t_div_req        o_div_req,
    input  lfp_pkg::t_div_rsp        i_div_rsp,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output lfp_pkg::t_result         o_result
);
    import lfp_pkg::*;

    localparam int IDX_W = $clog2(SENSOR_COUNT);
    localparam int CNT_W = IDX_W + 1;
    localparam int ERR_W = $clog2(SENSOR_COUNT) + 1;
    localparam int SUM_W = $clog2(SENSOR_COUNT * SENSOR_COUNT) + 1;
    localparam logic [2:0] TURN_SLOT = 3'd4;
    localparam int PROD_W = 56;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CDIV, S_CWAIT, S_LDIV, S_LWAIT, S_MUL,
        S_INTEG, S_CLAMP, S_MIX, S_RDIV, S_RWAIT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        MS_EMS, MS_KPE, MS_M1000, MS_T1, MS_KIS, MS_T2, MS_KDDE,
        MS_T3, MS_D, MS_TLC, MS_TLD, MS_VYC, MS_VYD, MS_HD
    } t_mstep;

    t_state                    r_state;
    t_mstep                    r_step;
    logic                      r_ph;
    logic [SENSOR_COUNT-1:0]   r_mask;
    logic [MS_W-1:0]           r_ms, r_m;
    logic                      r_lost;
    logic [IDX_W-1:0]          r_idx;
    logic signed [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [ERR_W-1:0]   r_e, r_last;
    logic [26:0]               r_lim;
    logic signed [31:0]        r_integ;
    logic signed [23:0]        r_ems, r_kpe, r_kdde;
    logic signed [31:0]        r_m1000, r_kis, r_tlc, r_vyc;
    logic signed [WIDE_W-1:0]  r_n, r_d, r_tld, r_vyd, r_hd, r_mx;
    logic                      r_scaled;
    logic [2:0]                r_k;
    logic [6:0]                r_mag [5];
    logic                      r_neg [5];
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_out_valid;
    t_result                   r_result;

    logic [6:0]                w_tl, w_vy;
    logic signed [SUM_W-1:0]   w_weight;
    logic [SUM_W-1:0]          w_sum_abs;
    logic signed [ERR_W:0]     w_de;
    logic signed [31:0]        w_ma;
    logic signed [23:0]        w_mb;
    logic signed [23:0]        w_e24;
    logic [23:0]               w_m24;
    logic signed [WIDE_W-1:0]  w_x, w_xs, w_absn, w_mx, w_rden;
    logic [WIDE_W-1:0]         w_xa, w_rnum;
    logic                      w_use_scale;
    logic signed [ERR_W-1:0]   w_cq;
    logic signed [33:0]        w_s, w_lim34;
    t_mstep                    w_step_nx;
    logic                      w_load;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;

    // The finished step moves into the result register once it is free.
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Saturated register views.
    assign w_tl = (i_cfg.tl > PCT_MAX) ? PCT_MAX : i_cfg.tl;
    assign w_vy = (i_cfg.vy > PCT_MAX) ? PCT_MAX : i_cfg.vy;

    // Sensor weight 2*i - (count-1) and centroid helpers.
    assign w_weight  = $signed({{(SUM_W-IDX_W-1){1'b0}}, r_idx, 1'b0})
                     - $signed(SUM_W'(SENSOR_COUNT - 1));
    assign w_sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_cq      = $signed(i_div_rsp.quo[ERR_W-1:0]);
    assign w_de      = $signed({r_e[ERR_W-1], r_e}) - $signed({r_last[ERR_W-1], r_last});
    assign w_e24     = {{(24-ERR_W){r_e[ERR_W-1]}}, r_e};
    assign w_m24     = {8'd0, r_m};
    assign w_step_nx = t_mstep'(r_step + 4'd1);

    // Integral update with clamp to the limit.
    assign w_s     = $signed({{2{r_integ[31]}}, r_integ}) + $signed({{10{r_ems[23]}}, r_ems});
    assign w_lim34 = $signed({7'd0, r_lim});

    // Operand select for the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_step)
            MS_EMS:   begin w_ma = $signed({16'd0, r_ms});       w_mb = w_e24; end
            MS_KPE:   begin w_ma = $signed({16'd0, i_cfg.kp});   w_mb = w_e24; end
            MS_M1000: begin w_ma = $signed({16'd0, r_m});        w_mb = 24'(SCALE_MS); end
            MS_T1:    begin w_ma = r_m1000;                      w_mb = r_kpe; end
            MS_KIS:   begin w_ma = r_integ;                      w_mb = $signed({8'd0, i_cfg.ki}); end
            MS_T2:    begin w_ma = r_kis;                        w_mb = $signed(w_m24); end
            MS_KDDE:  begin
                w_ma = $signed({16'd0, i_cfg.kd});
                w_mb = {{(24-ERR_W-1){w_de[ERR_W]}}, w_de};
            end
            MS_T3:    begin w_ma = 32'(SCALE_DERIV);             w_mb = r_kdde; end
            MS_D:     begin w_ma = 32'(SCALE_DEN);               w_mb = $signed(w_m24); end
            MS_TLC:   begin w_ma = $signed({25'd0, w_tl});       w_mb = 24'(SCALE_DEN); end
            MS_TLD:   begin w_ma = r_tlc;                        w_mb = $signed(w_m24); end
            MS_VYC:   begin w_ma = $signed({25'd0, w_vy});       w_mb = 24'(SCALE_DEN); end
            MS_VYD:   begin w_ma = r_vyc;                        w_mb = $signed(w_m24); end
            MS_HD:    begin w_ma = 32'(SCALE_FULL);              w_mb = $signed(w_m24); end
            default:  begin w_ma = '0;                           w_mb = '0; end
        endcase
    end

    // Mixing and rounding operands for the current wheel or the turn output.
    assign w_absn      = r_n[WIDE_W-1] ? -r_n : r_n;
    assign w_mx        = r_vyd + w_absn;
    assign w_use_scale = r_scaled && (r_k != TURN_SLOT);
    assign w_x         = (r_k == TURN_SLOT) ? r_n : (r_k[0] ? r_vyd - r_n : r_vyd + r_n);
    assign w_xs        = w_use_scale ? (w_x <<< 6) + (w_x <<< 5) + (w_x <<< 2) : w_x;
    assign w_xa        = w_xs[WIDE_W-1] ? WIDE_W'(-w_xs) : WIDE_W'(w_xs);
    assign w_rden      = w_use_scale ? r_mx : r_d;
    assign w_rnum      = (w_xa << 1) + WIDE_W'(w_rden);

    // Divider request by phase.
    always_comb begin
        o_div_req.start = 1'b0;
        o_div_req.num   = '0;
        o_div_req.den   = '0;
        o_div_req.iters = ITERS_RND;
        unique case (r_state)
            S_CDIV: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = WIDE_W'(w_sum_abs);
                o_div_req.den   = WIDE_W'(r_cnt);
                o_div_req.iters = 5'(SUM_W);
            end
            S_LDIV: begin
                o_div_req.start = (i_cfg.ki != 16'd0);
                o_div_req.num   = WIDE_W'(LIM_NUM);
                o_div_req.den   = WIDE_W'(i_cfg.ki);
                o_div_req.iters = ITERS_LIM;
            end
            S_RDIV: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = w_rnum;
                o_div_req.den   = WIDE_W'(w_rden) << 1;
                o_div_req.iters = ITERS_RND;
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer, datapath registers and the result register.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= MS_EMS;
            r_ph        <= 1'b0;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_last      <= '0;
        end else begin
            // Result valid: set on load, cleared when the beat is taken.
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_mask <= i_q_mask;
                        r_ms   <= i_q_ms;
                        r_m    <= (i_q_ms == '0) ? MS_W'(1) : i_q_ms;
                        r_lost <= i_q_lost;
                        r_idx  <= '0;
                        r_sum  <= '0;
                        r_cnt  <= '0;
                        if (i_q_lost) begin
                            // Search spin toward the side the line was last seen.
                            r_n     <= (r_last > 0) ? WIDE_W'(LOST_TURN) : -WIDE_W'(LOST_TURN);
                            r_d     <= WIDE_W'(1);
                            r_vyd   <= WIDE_W'(LOST_VY);
                            r_hd    <= WIDE_W'(PCT_MAX);
                            r_state <= S_MIX;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_mask[r_idx]) begin
                        r_sum <= r_sum + w_weight;
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(SENSOR_COUNT - 1)) begin
                        r_state <= S_CDIV;
                    end
                end
                S_CDIV: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (i_div_rsp.done) begin
                        r_e     <= r_sum[SUM_W-1] ? -w_cq : w_cq;
                        r_state <= S_LDIV;
                    end
                end
                S_LDIV: begin
                    if (i_cfg.ki == 16'd0) begin
                        r_lim   <= 27'(LIM_NO_KI);
                        r_step  <= MS_EMS;
                        r_ph    <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_LWAIT;
                    end
                end
                S_LWAIT: begin
                    if (i_div_rsp.done) begin
                        r_lim   <= 27'(i_div_rsp.quo);
                        r_step  <= MS_EMS;
                        r_ph    <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // With r_ph low the product is registered; with r_ph high it is stored.
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph   <= 1'b0;
                        r_step <= w_step_nx;
                        unique case (r_step)
                            MS_EMS:   begin
                                r_ems   <= r_prod[23:0];
                                r_state <= S_INTEG;
                            end
                            MS_KPE:   r_kpe   <= r_prod[23:0];
                            MS_M1000: r_m1000 <= r_prod[31:0];
                            MS_T1:    r_n     <= r_prod[WIDE_W-1:0];
                            MS_KIS:   r_kis   <= r_prod[31:0];
                            MS_T2:    r_n     <= r_n + r_prod[WIDE_W-1:0];
                            MS_KDDE:  r_kdde  <= r_prod[23:0];
                            MS_T3:    r_n     <= r_n + r_prod[WIDE_W-1:0];
                            MS_D:     r_d     <= r_prod[WIDE_W-1:0];
                            MS_TLC:   r_tlc   <= r_prod[31:0];
                            MS_TLD:   r_tld   <= r_prod[WIDE_W-1:0];
                            MS_VYC:   r_vyc   <= r_prod[31:0];
                            MS_VYD:   r_vyd   <= r_prod[WIDE_W-1:0];
                            MS_HD:    begin
                                r_hd    <= r_prod[WIDE_W-1:0];
                                r_state <= S_CLAMP;
                            end
                            default:  r_state <= S_CLAMP;
                        endcase
                    end
                end
                S_INTEG: begin
                    priority if (w_s > w_lim34) begin
                        r_integ <= 32'(w_lim34);
                    end else if (w_s < -w_lim34) begin
                        r_integ <= 32'(-w_lim34);
                    end else begin
                        r_integ <= 32'(w_s);
                    end
                    r_state <= S_MUL;
                end
                S_CLAMP: begin
                    priority if (r_n > r_tld) begin
                        r_n <= r_tld;
                    end else if (r_n < -r_tld) begin
                        r_n <= -r_tld;
                    end else begin
                        r_n <= r_n;
                    end
                    r_last  <= r_e;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_mx     <= w_mx;
                    r_scaled <= (w_mx > r_hd);
                    r_k      <= '0;
                    r_state  <= S_RDIV;
                end
                S_RDIV: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (i_div_rsp.done) begin
                        r_mag[r_k] <= i_div_rsp.quo[6:0];
                        r_neg[r_k] <= w_xs[WIDE_W-1] && (i_div_rsp.quo != '0);
                        if (r_k == TURN_SLOT) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_RDIV;
                        end
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        for (int k = 0; k < 4; k++) begin
                            r_result.duty[k] <= duty_of(r_mag[k]);
                            r_result.rev[k]  <= r_neg[k];
                        end
                        r_result.lost <= r_lost;
                        r_result.turn <= r_neg[4] ? -{1'b0, r_mag[4]} : {1'b0, r_mag[4]};
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/lfp_checker.sv */
// Port-level checks for the line-follow PID omni drive, bound to its top level.
// Depends only on the top level's ports.
module lfp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [7:0]        o_duty_wheel0,
    input logic              o_reverse_wheel0,
    input logic [7:0]        o_duty_wheel1,
    input logic              o_reverse_wheel1,
    input logic [7:0]        o_duty_wheel2,
    input logic              o_reverse_wheel2,
    input logic [7:0]        o_duty_wheel3,
    input logic              o_reverse_wheel3,
    input logic              o_line_lost,
    input logic signed [7:0] o_turn_rate
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_turn_rate)
            && $stable(o_duty_wheel0) && $stable(o_duty_wheel3))
        else $error("result beat changed while stalled");

    // A reversing wheel never has zero duty.
    a_rev_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_reverse_wheel0 || o_duty_wheel0 != 8'd0)
            && (!o_reverse_wheel1 || o_duty_wheel1 != 8'd0)
            && (!o_reverse_wheel2 || o_duty_wheel2 != 8'd0)
            && (!o_reverse_wheel3 || o_duty_wheel3 != 8'd0))
        else $error("reverse set with zero duty");

    // A running wheel gets at least the minimum duty.
    a_duty_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty_wheel0 == 8'd0 || o_duty_wheel0 >= 8'd150)
            && (o_duty_wheel1 == 8'd0 || o_duty_wheel1 >= 8'd150)
            && (o_duty_wheel2 == 8'd0 || o_duty_wheel2 >= 8'd150)
            && (o_duty_wheel3 == 8'd0 || o_duty_wheel3 >= 8'd150))
        else $error("duty below minimum");

    // The search spin is always plus or minus twelve.
    a_lost_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_lost |-> (o_turn_rate == 8'sd12 || o_turn_rate == -8'sd12))
        else $error("search spin has wrong turn rate");

    // The turn command stays within one hundred percent.
    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_turn_rate >= -8'sd100 && o_turn_rate <= 8'sd100))
        else $error("turn rate out of range");

endmodule

bind line_follow_pid_omni_drive lfp_checker u_lfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_duty_wheel0    (o_duty_wheel0),
    .o_reverse_wheel0 (o_reverse_wheel0),
    .o_duty_wheel1    (o_duty_wheel1),
    .o_reverse_wheel1 (o_reverse_wheel1),
    .o_duty_wheel2    (o_duty_wheel2),
    .o_reverse_wheel2 (o_reverse_wheel2),
    .o_duty_wheel3    (o_duty_wheel3),
    .o_reverse_wheel3 (o_reverse_wheel3),
    .o_line_lost      (o_line_lost),
    .o_turn_rate      (o_turn_rate)
);
